### src/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### src/aesp_pkg.sv
package aesp_pkg;

	// sequence limits and field widths
	localparam int MAX_SEQ_CHARS = 23;
	localparam int CNT_W         = 5;
	localparam int IDX_W         = $clog2(MAX_SEQ_CHARS);
	localparam int SEQ_W         = $clog2(MAX_SEQ_CHARS + 2);
	localparam int VAL_W         = 16;
	localparam int ENTRY_W       = VAL_W + 1;
	localparam int CMDQ_DEPTH    = 2;
	localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);

	localparam logic [VAL_W-1:0] VALUE_MAX = '1;

	// special bytes
	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_CSI    = 8'h9B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

	// result kinds
	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_ESC   = 2'd1;
	localparam logic [1:0] KIND_CSI   = 2'd2;

	// command from front to back
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       code;
		logic [CNT_W-1:0] count;
	} cmd_t;

	// parameter store write
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] data;
	} store_wr_t;

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
		       ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_ZERO) && (ch <= CH_NINE);
	endfunction

endpackage

### src/aesp_if.sv
// received byte channel
interface aesp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// parsed result channel
interface aesp_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [7:0]                 code;
	logic [aesp_pkg::VAL_W-1:0] param_value;
	logic                       param_private;
	logic [aesp_pkg::CNT_W-1:0] param_index;
	logic [aesp_pkg::CNT_W-1:0] param_count;
	logic                       last;

	modport source (output valid, output kind, output code, output param_value,
		output param_private, output param_index, output param_count,
		output last, input ready);
	modport sink   (input valid, input kind, input code, input param_value,
		input param_private, input param_index, input param_count,
		input last, output ready);
endinterface

### src/ansi_escape_sequence_parser_top.sv
// ANSI/VT100 escape sequence parser.
// in_ch carries one received byte per transaction (valid/ready). out_ch carries
// parsed results: plain bytes, escape commands and control-sequence parameters,
// each with kind, code, parameter fields and last.
// A byte that gives a single result reaches out_ch through the command queue and
// the output register. A final letter that closes a sequence with N parameters
// gives them through the queue, the RAM read and the output register, one per
// cycle while the receiver is ready, from the RAM's single registered read port.
// The input takes one byte per cycle; it is held off only while the command
// queue is full, or while a parameter run is still being read out and the next
// control sequence would overwrite the parameter RAM.
// Reset (arst_n low) returns the parser to idle, empties the queue and drops any
// pending result; no clearing pass is needed, the RAM is only read below the
// parameter count of the current sequence.
// When the receiver stalls, the output register holds its transaction and the
// queue fills; the input then stops accepting once the queue is full.
`include "assert_macros.svh"

module ansi_escape_sequence_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	aesp_in_if.sink    in_ch,
	aesp_out_if.source out_ch
);

	aesp_pkg::cmd_t                  push_cmd;
	aesp_pkg::cmd_t                  pop_cmd;
	aesp_pkg::store_wr_t             st_wr;
	logic                            cmd_push;
	logic                            cmd_pop;
	logic                            cmd_full;
	logic                            cmd_empty;
	logic                            run_done;
	logic                            run_busy;
	logic                            rd_en;
	logic [aesp_pkg::IDX_W-1:0]      rd_addr;
	logic [aesp_pkg::ENTRY_W-1:0]    rd_data;

	aesp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (push_cmd),
		.st_wr    (st_wr),
		.run_done (run_done),
		.run_busy (run_busy)
	);

	aesp_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.cmd_in  (push_cmd),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.cmd_out (pop_cmd),
		.empty   (cmd_empty)
	);

	aesp_ram #(
		.WIDTH (aesp_pkg::ENTRY_W),
		.DEPTH (aesp_pkg::MAX_SEQ_CHARS)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr.en),
		.wr_addr (st_wr.addr),
		.wr_data (st_wr.data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	aesp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (pop_cmd),
		.cmd_pop   (cmd_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.run_done  (run_done),
		.out_ch    (out_ch)
	);

	// store is never written while a run is being read out
	`AST_IMP(a_no_store_wr_busy, clk, arst_n, st_wr.en, !run_busy)
	// queue never pushed when full
	`AST_IMP(a_no_q_overflow, clk, arst_n, cmd_push, !cmd_full)
	// a non-final parameter on the output belongs to a live run
	`AST_IMP(a_run_live, clk, arst_n, out_ch.valid && (out_ch.kind == aesp_pkg::KIND_CSI) && !out_ch.last, run_busy)
	// finishing a run frees the store for the next sequence
	`AST_NEXT(a_run_release, clk, arst_n, run_done, !run_busy)

endmodule

### src/aesp_ram.sv
// Simple dual-port RAM, registered read
module aesp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/aesp_front.sv
// Byte classifier: mode tracking, parameter cutting, command issue
module aesp_front (
	input  logic                clk,
	input  logic                arst_n,
	aesp_in_if.sink             in_ch,
	input  logic                cmd_full,
	output logic                cmd_push,
	output aesp_pkg::cmd_t      cmd,
	output aesp_pkg::store_wr_t st_wr,
	input  logic                run_done,
	output logic                run_busy
);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_ESC     = 2'd1;
	localparam logic [1:0] MODE_CSI     = 2'd2;
	localparam logic [1:0] MODE_CHARSET = 2'd3;

	logic [1:0]                 mode_q, mode_n;
	logic [aesp_pkg::SEQ_W-1:0] stored_q, stored_n;
	logic                       open_q, open_n;
	logic                       priv_q, priv_n;
	logic [aesp_pkg::VAL_W-1:0] acc_q, acc_n;
	logic [aesp_pkg::CNT_W-1:0] held_q, held_n;
	logic                       run_busy_q, run_busy_n;

	logic                       take;
	logic [7:0]                 ch;
	logic [aesp_pkg::VAL_W+3:0] prod;
	logic [aesp_pkg::VAL_W-1:0] acc_sat;
	logic                       do_close;
	logic                       do_clear;
	logic [aesp_pkg::VAL_W-1:0] close_val;
	logic                       close_priv;
	logic                       room;

	assign ch       = in_ch.rx_byte;
	// hold off while the queue is full, or while a run is still reading the store in CSI mode
	assign in_ch.ready = !cmd_full && !(run_busy_q && (mode_q == MODE_CSI));
	assign take     = in_ch.valid && in_ch.ready;
	assign run_busy = run_busy_q;
	assign room     = held_q < aesp_pkg::CNT_W'(aesp_pkg::MAX_SEQ_CHARS);

	// decimal accumulate with saturation
	always_comb begin
		prod = (aesp_pkg::VAL_W+4)'(acc_q) * (aesp_pkg::VAL_W+4)'(10)
		     + (aesp_pkg::VAL_W+4)'(ch[3:0]);
		acc_sat = (prod > (aesp_pkg::VAL_W+4)'(aesp_pkg::VALUE_MAX)) ?
			aesp_pkg::VALUE_MAX : prod[aesp_pkg::VAL_W-1:0];
	end

	// next state
	always_comb begin
		mode_n     = mode_q;
		stored_n   = stored_q;
		open_n     = open_q;
		priv_n     = priv_q;
		acc_n      = acc_q;
		held_n     = held_q;
		run_busy_n = run_busy_q;
		cmd_push   = 1'b0;
		cmd        = '0;
		st_wr      = '0;
		do_close   = 1'b0;
		do_clear   = 1'b0;
		close_val  = '0;
		close_priv = 1'b0;

		if (take) begin
			if (ch == aesp_pkg::BYTE_ESC) begin
				do_clear = 1'b1;
				mode_n   = MODE_ESC;
			end else if (ch == aesp_pkg::BYTE_CSI) begin
				do_clear = 1'b1;
				mode_n   = MODE_CSI;
			end else begin
				case (mode_q)
					MODE_ESC: begin
						if (ch == aesp_pkg::CH_LBRACKET) begin
							do_clear = 1'b1;
							mode_n   = MODE_CSI;
						end else if ((ch == aesp_pkg::CH_LPAREN) ||
						             (ch == aesp_pkg::CH_RPAREN)) begin
							mode_n = MODE_CHARSET;
						end else begin
							mode_n   = MODE_IDLE;
							cmd_push = 1'b1;
							cmd      = '{kind: aesp_pkg::KIND_ESC, code: ch, count: '0};
						end
					end
					MODE_CHARSET: begin
						mode_n = MODE_IDLE;
					end
					MODE_CSI: begin
						if (aesp_pkg::is_letter(ch)) begin
							// final letter: close open element, hand the run over
							do_close   = open_q;
							close_val  = acc_q;
							close_priv = priv_q;
							do_clear   = 1'b1;
							mode_n     = MODE_IDLE;
							cmd_push   = 1'b1;
							cmd.kind   = aesp_pkg::KIND_CSI;
							cmd.code   = ch;
							cmd.count  = held_q + aesp_pkg::CNT_W'(open_q && room);
							if (cmd.count != '0) begin
								run_busy_n = 1'b1;
							end
						end else if (stored_q >=
						             aesp_pkg::SEQ_W'(aesp_pkg::MAX_SEQ_CHARS)) begin
							// overlong: drop silently
							do_clear = 1'b1;
							mode_n   = MODE_IDLE;
						end else begin
							stored_n = stored_q + 1'b1;
							if (!open_q) begin
								if (ch == aesp_pkg::CH_QMARK) begin
									open_n = 1'b1;
									priv_n = 1'b1;
									acc_n  = '0;
								end else if (aesp_pkg::is_digit(ch)) begin
									open_n = 1'b1;
									priv_n = 1'b0;
									acc_n  = aesp_pkg::VAL_W'(ch[3:0]);
								end else begin
									do_close = 1'b1;
								end
							end else if (aesp_pkg::is_digit(ch)) begin
								acc_n = acc_sat;
							end else begin
								do_close   = 1'b1;
								close_val  = acc_q;
								close_priv = priv_q;
							end
						end
					end
					default: begin
						mode_n   = MODE_IDLE;
						cmd_push = 1'b1;
						cmd      = '{kind: aesp_pkg::KIND_PLAIN, code: ch, count: '0};
					end
				endcase
			end
		end

		// element close: store while there is room
		if (do_close) begin
			if (room) begin
				st_wr.en   = 1'b1;
				st_wr.addr = held_q[aesp_pkg::IDX_W-1:0];
				st_wr.data = {close_priv, close_val};
				held_n     = held_q + 1'b1;
			end
			open_n = 1'b0;
			priv_n = 1'b0;
			acc_n  = '0;
		end

		// sequence clear
		if (do_clear) begin
			stored_n = '0;
			open_n   = 1'b0;
			priv_n   = 1'b0;
			acc_n    = '0;
			held_n   = '0;
		end

		if (run_done) begin
			run_busy_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			stored_q   <= '0;
			open_q     <= 1'b0;
			priv_q     <= 1'b0;
			acc_q      <= '0;
			held_q     <= '0;
			run_busy_q <= 1'b0;
		end else begin
			mode_q     <= mode_n;
			stored_q   <= stored_n;
			open_q     <= open_n;
			priv_q     <= priv_n;
			acc_q      <= acc_n;
			held_q     <= held_n;
			run_busy_q <= run_busy_n;
		end
	end

endmodule

### src/aesp_cmdq.sv
// Short command queue between front and back
module aesp_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aesp_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output aesp_pkg::cmd_t cmd_out,
	output logic           empty
);

	aesp_pkg::cmd_t                  entry_q [aesp_pkg::CMDQ_DEPTH];
	logic [aesp_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [aesp_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [aesp_pkg::CMDQ_CNT_W-1:0] fill_q;

	assign full    = fill_q == aesp_pkg::CMDQ_CNT_W'(aesp_pkg::CMDQ_DEPTH);
	assign empty   = fill_q == '0;
	assign cmd_out = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == aesp_pkg::CMDQ_PTR_W'(aesp_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == aesp_pkg::CMDQ_PTR_W'(aesp_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

### src/aesp_back.sv
// Result generator: expands commands into result transactions
module aesp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_empty,
	input  aesp_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         rd_en,
	output logic [aesp_pkg::IDX_W-1:0]   rd_addr,
	input  logic [aesp_pkg::ENTRY_W-1:0] rd_data,
	output logic                         run_done,
	aesp_out_if.source                   out_ch
);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_EMIT = 1'b1;

	logic                       state_q, state_n;
	logic [7:0]                 code_q, code_n;
	logic [aesp_pkg::CNT_W-1:0] count_q, count_n;
	logic [aesp_pkg::CNT_W-1:0] idx_q, idx_n;

	logic                       out_valid_q;
	logic [1:0]                 kind_q;
	logic [7:0]                 ocode_q;
	logic [aesp_pkg::VAL_W-1:0] value_q;
	logic                       priv_q;
	logic [aesp_pkg::CNT_W-1:0] oidx_q;
	logic [aesp_pkg::CNT_W-1:0] ocount_q;
	logic                       last_q;

	logic                       out_free;
	logic                       load;
	logic [1:0]                 ld_kind;
	logic [7:0]                 ld_code;
	logic [aesp_pkg::VAL_W-1:0] ld_value;
	logic                       ld_priv;
	logic [aesp_pkg::CNT_W-1:0] ld_idx;
	logic [aesp_pkg::CNT_W-1:0] ld_count;
	logic                       ld_last;
	logic                       is_last;

	assign out_free = !out_valid_q || out_ch.ready;
	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty && out_free;
	assign is_last  = (idx_q + 1'b1) == count_q;

	// sequencing
	always_comb begin
		state_n  = state_q;
		code_n   = code_q;
		count_n  = count_q;
		idx_n    = idx_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		run_done = 1'b0;
		load     = 1'b0;
		ld_kind  = cmd.kind;
		ld_code  = cmd.code;
		ld_value = '0;
		ld_priv  = 1'b0;
		ld_idx   = '0;
		ld_count = '0;
		ld_last  = 1'b1;

		case (state_q)
			B_IDLE: begin
				if (cmd_pop) begin
					if ((cmd.kind == aesp_pkg::KIND_CSI) && (cmd.count != '0)) begin
						// start run: fetch first parameter
						state_n = B_EMIT;
						code_n  = cmd.code;
						count_n = cmd.count;
						idx_n   = '0;
						rd_en   = 1'b1;
					end else begin
						load = 1'b1;
					end
				end
			end
			B_EMIT: begin
				if (out_free) begin
					load     = 1'b1;
					ld_kind  = aesp_pkg::KIND_CSI;
					ld_code  = code_q;
					ld_value = rd_data[aesp_pkg::VAL_W-1:0];
					ld_priv  = rd_data[aesp_pkg::ENTRY_W-1];
					ld_idx   = idx_q;
					ld_count = count_q;
					ld_last  = is_last;
					if (is_last) begin
						state_n  = B_IDLE;
						run_done = 1'b1;
					end else begin
						idx_n   = idx_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_n[aesp_pkg::IDX_W-1:0];
					end
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		code_q  <= code_n;
		count_q <= count_n;
		idx_q   <= idx_n;
		if (load) begin
			kind_q   <= ld_kind;
			ocode_q  <= ld_code;
			value_q  <= ld_value;
			priv_q   <= ld_priv;
			oidx_q   <= ld_idx;
			ocount_q <= ld_count;
			last_q   <= ld_last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.kind          = kind_q;
	assign out_ch.code          = ocode_q;
	assign out_ch.param_value   = value_q;
	assign out_ch.param_private = priv_q;
	assign out_ch.param_index   = oidx_q;
	assign out_ch.param_count   = ocount_q;
	assign out_ch.last          = last_q;

endmodule

### sim/ansi_escape_sequence_parser_top_test.sv
module ansi_escape_sequence_parser_top_test;
	import aesp_pkg::*;

	typedef enum logic [1:0] {
		PM_IDLE,
		PM_ESC,
		PM_CSI,
		PM_CHARSET
	} parse_mode_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       code;
		logic [VAL_W-1:0] value;
		logic             priv;
		logic [CNT_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             last;
	} result_t;

	// directed row: byte, whether the outcome is written out here, and that outcome
	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		logic       has_res;
		logic [1:0] kind;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_ITEMS  = 195;

	logic clk;
	logic arst_n;
	logic sink_ready = 1'b0;
	logic calm = 1'b0;
	int   mismatches = 0;
	int   random_items = 0;

	aesp_in_if  in_ch ();
	aesp_out_if out_ch ();

	assign out_ch.ready = sink_ready;

	ansi_escape_sequence_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// after reset, extremes, escape command, charset skip, bare CSI, parameter mix
	stim_row_t stim_table [DIRECTED_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, KIND_PLAIN},
		'{8'hFF, 1'b1, 1'b1, KIND_PLAIN},
		'{BYTE_ESC, 1'b1, 1'b0, KIND_PLAIN},
		'{8'h4D, 1'b1, 1'b1, KIND_ESC},
		'{BYTE_ESC, 1'b1, 1'b0, KIND_PLAIN},
		'{CH_LPAREN, 1'b1, 1'b0, KIND_PLAIN},
		'{8'h42, 1'b1, 1'b0, KIND_PLAIN},
		'{BYTE_CSI, 1'b1, 1'b0, KIND_PLAIN},
		'{8'h48, 1'b1, 1'b1, KIND_CSI},
		'{BYTE_ESC, 1'b0, 1'b0, KIND_PLAIN},
		'{CH_LBRACKET, 1'b0, 1'b0, KIND_PLAIN},
		'{CH_QMARK, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h37, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h3B, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h3B, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h39, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h39, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h39, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h39, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h39, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h80, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h7A, 1'b0, 1'b0, KIND_PLAIN},
		'{8'h5A, 1'b1, 1'b1, KIND_PLAIN}
	};

	// parser state as predicted
	parse_mode_t      pmode = PM_IDLE;
	int               seq_bytes = 0;
	logic             elem_open = 1'b0;
	logic             elem_priv = 1'b0;
	int               elem_acc = 0;
	logic [VAL_W-1:0] pval [MAX_SEQ_CHARS];
	logic             ppriv [MAX_SEQ_CHARS];
	int               pheld = 0;

	result_t    fresh_results [$];
	result_t    pending_results [$];
	logic [7:0] burst [$];

	function automatic logic letter_byte(input logic [7:0] ch);
		return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
	endfunction

	function automatic logic digit_byte(input logic [7:0] ch);
		return ch >= 8'h30 && ch <= 8'h39;
	endfunction

	function automatic void stage(input logic [1:0] kind, input logic [7:0] code,
		input logic [VAL_W-1:0] value, input logic priv, input int index,
		input int count, input logic last);
		result_t r;
		r = '{kind, code, value, priv, index[CNT_W-1:0], count[CNT_W-1:0], last};
		fresh_results.push_back(r);
	endfunction

	function automatic void wipe_sequence();
		seq_bytes = 0;
		elem_open = 1'b0;
		elem_priv = 1'b0;
		elem_acc  = 0;
		pheld     = 0;
	endfunction

	function automatic void close_param(input int value, input logic priv);
		if (pheld < MAX_SEQ_CHARS) begin
			pval[pheld]  = value[VAL_W-1:0];
			ppriv[pheld] = priv;
			pheld++;
		end
		elem_open = 1'b0;
		elem_priv = 1'b0;
		elem_acc  = 0;
	endfunction

	// one received byte through the predicted parser; results land in fresh_results
	function automatic void parse_byte(input logic [7:0] ch);
		int v;
		fresh_results.delete();
		if (ch == BYTE_ESC) begin
			wipe_sequence();
			pmode = PM_ESC;
		end else if (ch == BYTE_CSI) begin
			wipe_sequence();
			pmode = PM_CSI;
		end else begin
			case (pmode)
				PM_ESC: begin
					if (ch == CH_LBRACKET) begin
						wipe_sequence();
						pmode = PM_CSI;
					end else if (ch == CH_LPAREN || ch == CH_RPAREN) begin
						pmode = PM_CHARSET;
					end else begin
						pmode = PM_IDLE;
						stage(KIND_ESC, ch, '0, 1'b0, 0, 0, 1'b1);
					end
				end
				PM_CHARSET: pmode = PM_IDLE;
				PM_CSI: begin
					if (letter_byte(ch)) begin
						if (elem_open)
							close_param(elem_acc, elem_priv);
						pmode = PM_IDLE;
						if (pheld == 0)
							stage(KIND_CSI, ch, '0, 1'b0, 0, 0, 1'b1);
						for (int i = 0; i < pheld; i++)
							stage(KIND_CSI, ch, pval[i], ppriv[i], i, pheld, i + 1 == pheld);
						wipe_sequence();
					end else begin
						seq_bytes++;
						if (seq_bytes > MAX_SEQ_CHARS) begin
							// overlong: dropped without a result
							wipe_sequence();
							pmode = PM_IDLE;
						end else if (!elem_open) begin
							if (ch == CH_QMARK) begin
								elem_open = 1'b1;
								elem_priv = 1'b1;
								elem_acc  = 0;
							end else if (digit_byte(ch)) begin
								elem_open = 1'b1;
								elem_priv = 1'b0;
								elem_acc  = int'(ch) - int'(CH_ZERO);
							end else begin
								close_param(0, 1'b0);
							end
						end else if (digit_byte(ch)) begin
							v = elem_acc * 10 + (int'(ch) - int'(CH_ZERO));
							elem_acc = (v > int'(VALUE_MAX)) ? int'(VALUE_MAX) : v;
						end else begin
							close_param(elem_acc, elem_priv);
						end
					end
				end
				default: begin
					pmode = PM_IDLE;
					stage(KIND_PLAIN, ch, '0, 1'b0, 0, 0, 1'b1);
				end
			endcase
		end
	endfunction

	// drive one byte, wait for its transaction, then book what it should give
	task automatic send_byte(input logic [7:0] ch, input logic typed, input logic has_res,
		input logic [1:0] kind);
		if (!calm && $urandom_range(0, 99) < 30) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.rx_byte <= ch;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		parse_byte(ch);
		if (typed) begin
			if (has_res)
				pending_results.push_back('{kind, ch, '0, 1'b0, '0, '0, 1'b1});
		end else begin
			foreach (fresh_results[i])
				pending_results.push_back(fresh_results[i]);
		end
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 25)) :
			8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	// any stored byte that is neither digit, letter nor a restart
	function automatic logic [7:0] rand_separator();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(0, 255));
		while (letter_byte(ch) || digit_byte(ch) || ch == BYTE_ESC || ch == BYTE_CSI);
		return ch;
	endfunction

	function automatic void plan_sequence(input int seq_no);
		int elems;
		int ndig;
		burst.delete();
		if (seq_no == 0) begin
			// full parameter store: 22 empty elements and one digit
			burst.push_back(BYTE_CSI);
			repeat (22) burst.push_back(8'h3B);
			burst.push_back(rand_digit());
			burst.push_back(rand_letter());
		end else if (seq_no == 1) begin
			// one stored byte too many, then a letter that passes through
			burst.push_back(BYTE_CSI);
			repeat (MAX_SEQ_CHARS + 1)
				burst.push_back($urandom_range(0, 1) ? rand_digit() : 8'h3B);
			burst.push_back(rand_letter());
		end else begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
				2: begin
					burst.push_back(BYTE_ESC);
					burst.push_back($urandom_range(0, 1) ? rand_letter() :
						8'($urandom_range(0, 255)));
				end
				3: begin
					burst.push_back(BYTE_ESC);
					burst.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
					burst.push_back(8'($urandom_range(0, 255)));
				end
				9: begin
					// broken sequence: restart part way, or run past the limit
					burst.push_back(BYTE_CSI);
					if ($urandom_range(0, 1)) begin
						repeat ($urandom_range(0, 5))
							burst.push_back($urandom_range(0, 1) ? rand_digit() : 8'h3B);
						burst.push_back(BYTE_ESC);
					end else begin
						repeat ($urandom_range(MAX_SEQ_CHARS + 1, MAX_SEQ_CHARS + 3))
							burst.push_back($urandom_range(0, 1) ? rand_digit() : rand_separator());
					end
					burst.push_back(rand_letter());
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						burst.push_back(BYTE_ESC);
						burst.push_back(CH_LBRACKET);
					end else begin
						burst.push_back(BYTE_CSI);
					end
					elems = $urandom_range(0, 4);
					for (int e = 0; e < elems; e++) begin
						if (e > 0)
							burst.push_back($urandom_range(0, 3) == 0 ? rand_separator() : 8'h3B);
						if ($urandom_range(0, 3) == 0)
							burst.push_back(CH_QMARK);
						ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
						repeat (ndig) burst.push_back(rand_digit());
					end
					burst.push_back(rand_letter());
				end
			endcase
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk)
		sink_ready <= calm || ($urandom_range(0, 99) >= 30);

	// compare each result transaction with the oldest booked one
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d code %02h",
					$time, out_ch.kind, out_ch.code);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, out_ch.kind);
				check_field("code", want.code, out_ch.code);
				check_field("param_value", want.value, out_ch.param_value);
				check_field("param_private", want.priv, out_ch.param_private);
				check_field("param_index", want.index, out_ch.param_index);
				check_field("param_count", want.count, out_ch.param_count);
				check_field("last", want.last, out_ch.last);
			end
		end
	end

	// stimulus and end of run
	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.rx_byte = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i])
			send_byte(stim_table[i].ch, stim_table[i].typed, stim_table[i].has_res,
				stim_table[i].kind);

		for (int s = 0; random_items < RANDOM_ITEMS; s++) begin
			plan_sequence(s);
			foreach (burst[j]) begin
				// a stretch with no idling on either side
				calm = (random_items >= 100 && random_items < 160);
				send_byte(burst[j], 1'b0, 1'b0, KIND_PLAIN);
				random_items++;
			end
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("ansi_escape_sequence_parser_top regression: pass");
		else
			$display("ansi_escape_sequence_parser_top regression: fail");
		$finish;
	end

	// hang guard
	initial begin
		#5000000;
		$display("ansi_escape_sequence_parser_top regression: fail");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/aesp_pkg.sv
src/aesp_if.sv
src/aesp_ram.sv
src/aesp_front.sv
src/aesp_cmdq.sv
src/aesp_back.sv
src/ansi_escape_sequence_parser_top.sv
sim/ansi_escape_sequence_parser_top_test.sv
